// ===== src/pcmvol_pkg.sv =====
// Shared types and constants for the PCM16 volume and peak normalizer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pcmvol_pkg;

    localparam int VOLUME_FLOOR_DEF   = -6000;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;
    // Volume is kept as range + volume, which never exceeds the range.
    localparam int VOL_W     = 16;

    // Gain numerator is 0.98 * 32767 written as 49 * 32767 / 50.
    localparam int PEAK_NUM   = 49 * 32767;
    localparam int PEAK_DEN   = 50;
    localparam int PEAK_NUM_W = 21;
    localparam int PEAK_W     = 15;
    localparam int DEN_W      = 21;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTENUATE = 2'd2;

    typedef struct packed {
        logic capture;
        logic att_load;
        logic gain_start;
        logic gain_load;
        logic mul1;
        logic mul_lo;
        logic mul_hi;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic att_dirty;
        logic new_peak;
        logic div_busy;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== src/pcmvol_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Instantiated by pcmvol_dp; no package dependency.
`default_nettype none

module pcmvol_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 21
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  busy,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // The numerator shifts out of the top of quo_reg while quotient bits enter at the bottom.
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/pcmvol_ctrl.sv =====
// Controller state machine: sequences capture, divides, multiplies and output.
// Depends on pcmvol_pkg for the command and status structs.
`default_nettype none

module pcmvol_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire pcmvol_pkg::status_t status,
    output pcmvol_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_GAIN_WAIT,
        ST_MUL1,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START;
                    ready_next  = 1'b0;
                end
            end
            ST_START:
            begin
                // The attenuation factor is refreshed in this state when it is dirty.
                if (status.att_dirty)
                begin
                    cmd.att_load = 1'b1;
                end
                if (status.new_peak)
                begin
                    cmd.gain_start = 1'b1;
                    state_next     = ST_GAIN_WAIT;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_GAIN_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.gain_load = 1'b1;
                    state_next    = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here while the previous result has not been taken.
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                    ready_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

    a_gain_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gain_start |-> !status.div_busy)
        else $error("gain divide started while the divider is busy");

    a_mul_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL1 |-> !status.div_busy)
        else $error("multiply started while the divider is busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.out_busy)
        else $error("result register overwritten before transfer");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (ready_reg && state_reg == ST_IDLE))
        else $error("block not ready after loading a result");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");

endmodule

`default_nettype wire

// ===== src/pcmvol_dp.sv =====
// Datapath: configuration registers, peak and gain state, factor cache,
// multiplier stages and result register. Depends on pcmvol_pkg and pcmvol_div.
`default_nettype none

module pcmvol_dp #(
    parameter int VOLUME_FLOOR   = pcmvol_pkg::VOLUME_FLOOR_DEF,
    parameter int GAIN_FRAC_BITS = pcmvol_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [pcmvol_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcmvol_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic [pcmvol_pkg::SAMPLE_W-1:0]      s_tdata,
    input  wire logic                                 s_tlast,
    input  wire pcmvol_pkg::cmd_t                     cmd,
    output pcmvol_pkg::status_t                       status,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [pcmvol_pkg::SAMPLE_W-1:0]           m_tdata,
    output logic                                      m_tlast,
    output logic                                      m_tuser
);

    localparam int F      = GAIN_FRAC_BITS;
    localparam int RANGE  = -VOLUME_FLOOR;
    localparam int SW     = pcmvol_pkg::SAMPLE_W;
    localparam int VOL_W  = pcmvol_pkg::VOL_W;
    localparam int PEAK_W = pcmvol_pkg::PEAK_W;
    localparam int DEN_W  = pcmvol_pkg::DEN_W;
    localparam int NUM_W  = pcmvol_pkg::PEAK_NUM_W + F;
    localparam int GAIN_W = F + 2;
    localparam int ATT_W  = F + 1;
    localparam int AH     = (ATT_W + 1) / 2;
    localparam int AHI    = ATT_W - AH;
    localparam int P1W    = SW + GAIN_W;
    localparam int LO_W   = P1W + AH;
    localparam int HI_W   = P1W + AHI;
    localparam int ACC_W  = P1W + ATT_W;
    localparam int RES_W  = ACC_W - 2 * F;

    // The attenuation factor floor(v * 2^F / RANGE) is a reciprocal multiply. With the
    // shift above twice the bits of RANGE the result is exact for every v up to RANGE.
    localparam int          RECIP_SH = 2 * $clog2(RANGE) + 1;
    localparam int          RECIP_W  = F + RECIP_SH - $clog2(RANGE) + 2;
    localparam logic [63:0] RECIP    = ((64'd1 << (F + RECIP_SH)) / 64'(RANGE)) + 64'd1;
    localparam int          APROD_W  = VOL_W + RECIP_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = {2'b01, {F{1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_CAP = {2'b11, {F{1'b0}}};
    localparam logic [ATT_W-1:0]  ATT_ONE  = {1'b1, {F{1'b0}}};

    // Configuration and persistent state.
    logic [VOL_W-1:0]  vol_num_reg;
    logic              norm_en_reg;
    logic              att_en_reg;
    logic              att_dirty_reg;
    logic [PEAK_W-1:0] peak_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [ATT_W-1:0]  att_reg;
    logic              new_peak_reg;
    logic              out_valid_reg;

    // Per-sample working registers.
    logic              neg_reg;
    logic              last_reg;
    logic [SW-1:0]     mag_reg;
    logic [P1W-1:0]    p1_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [SW-1:0]     out_data_reg;
    logic              out_last_reg;
    logic              out_clip_reg;

    int                vol_int;
    int                vol_num_int;
    logic              take_peak;
    logic [NUM_W-1:0]  div_numer;
    logic [DEN_W-1:0]  div_denom;
    logic              div_busy;
    logic [NUM_W-1:0]  div_quo;
    logic [APROD_W-1:0] att_prod;
    logic [LO_W-1:0]   lo_prod;
    logic [HI_W-1:0]   hi_prod;
    logic [RES_W-1:0]  res;
    logic [SW-1:0]     sat_data;
    logic              sat_clip;

    // A volume write is sign-extended and saturated to the floor and to zero.
    always_comb
    begin
        vol_int = int'($signed(cfg_wdata));
        if (vol_int > 0)
        begin
            vol_num_int = RANGE;
        end
        else if (vol_int < VOLUME_FLOOR)
        begin
            vol_num_int = 0;
        end
        else
        begin
            vol_num_int = RANGE + vol_int;
        end
    end

    assign take_peak = norm_en_reg && !s_tdata[SW-1] && (s_tdata[PEAK_W-1:0] > peak_reg);

    assign att_prod = APROD_W'(vol_num_reg) * APROD_W'(RECIP[RECIP_W-1:0]);

    assign div_numer = {pcmvol_pkg::PEAK_NUM_W'(pcmvol_pkg::PEAK_NUM), {F{1'b0}}};
    assign div_denom = DEN_W'(peak_reg * DEN_W'(pcmvol_pkg::PEAK_DEN));

    pcmvol_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.gain_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_num_reg   <= VOL_W'(RANGE);
            norm_en_reg   <= 1'b0;
            att_en_reg    <= 1'b1;
            att_dirty_reg <= 1'b0;
            peak_reg      <= '0;
            gain_reg      <= GAIN_ONE;
            att_reg       <= ATT_ONE;
            new_peak_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.att_load)
            begin
                att_reg       <= att_en_reg ? att_prod[RECIP_SH+ATT_W-1:RECIP_SH] : ATT_ONE;
                att_dirty_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pcmvol_pkg::REG_VOLUME:
                    begin
                        vol_num_reg   <= VOL_W'(vol_num_int);
                        att_dirty_reg <= 1'b1;
                    end
                    pcmvol_pkg::REG_NORMALISE:
                    begin
                        norm_en_reg <= cfg_wdata[0];
                    end
                    pcmvol_pkg::REG_ATTENUATE:
                    begin
                        att_en_reg    <= cfg_wdata[0];
                        att_dirty_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.capture)
            begin
                new_peak_reg <= take_peak;
                if (!norm_en_reg)
                begin
                    gain_reg <= GAIN_ONE;
                end
                if (take_peak)
                begin
                    peak_reg <= s_tdata[PEAK_W-1:0];
                end
            end
            if (cmd.gain_load)
            begin
                if (div_quo > NUM_W'(GAIN_CAP))
                begin
                    gain_reg <= GAIN_CAP;
                end
                else
                begin
                    gain_reg <= div_quo[GAIN_W-1:0];
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The product is mag * gain * att; att is applied in two halves.
    always_comb
    begin
        lo_prod = LO_W'(p1_reg) * LO_W'(att_reg[AH-1:0]);
        hi_prod = HI_W'(p1_reg) * HI_W'(att_reg[ATT_W-1:AH]);
        res     = acc_reg[ACC_W-1:2*F];
        if (neg_reg)
        begin
            sat_clip = res > RES_W'(32768);
            sat_data = sat_clip ? {1'b1, {(SW-1){1'b0}}} : SW'(0) - res[SW-1:0];
        end
        else
        begin
            sat_clip = res > RES_W'(32767);
            sat_data = sat_clip ? {1'b0, {(SW-1){1'b1}}} : res[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            neg_reg  <= s_tdata[SW-1];
            last_reg <= s_tlast;
            mag_reg  <= s_tdata[SW-1] ? SW'(0) - s_tdata : s_tdata;
        end
        if (cmd.mul1)
        begin
            p1_reg <= P1W'(mag_reg) * P1W'(gain_reg);
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= ACC_W'(lo_prod);
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + {hi_prod, {AH{1'b0}}};
        end
        if (cmd.out_load)
        begin
            out_data_reg <= sat_data;
            out_last_reg <= last_reg;
            out_clip_reg <= sat_clip;
        end
    end

    always_comb
    begin
        status.att_dirty = att_dirty_reg;
        status.new_peak  = new_peak_reg;
        status.div_busy  = div_busy;
        status.out_busy  = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_clip_reg;

endmodule

`default_nettype wire

// ===== src/pcm16_volume_and_peak_normaliser_core.sv =====
// Top level of the PCM16 volume and peak normalizer: controller plus datapath.
// Depends on pcmvol_pkg, pcmvol_ctrl, pcmvol_dp and pcmvol_div.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  tdata: sample_in; tlast: buffer_end
//   m_*       out        m_tvalid / m_tready  tdata: sample_out; tlast: buffer_end_out;
//                                             tuser: clipped
//   cfg_*     in         cfg_we               cfg_index, cfg_wdata
//
// After its input transfer a sample is captured and passes the start, multiply and done
// states; no new sample is taken before it is through. The attenuation factor is
// refreshed by a reciprocal multiply in the start state, so a write to volume_millibel or
// attenuate_enable adds no wait. A new peak adds a wait for the serial gain divide.
// Reset is asynchronous and needs no clearing pass; the block is ready right after.
// A result waits in the output register while the next sample is taken and worked on;
// only the final load waits for that register to be free.
`default_nettype none

module pcm16_volume_and_peak_normaliser_core #(
    parameter int VOLUME_FLOOR   = pcmvol_pkg::VOLUME_FLOOR_DEF,
    parameter int GAIN_FRAC_BITS = pcmvol_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pcmvol_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pcmvol_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pcmvol_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [pcmvol_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
    output logic                                  m_tlast,
    output logic                                  m_tuser    // [0] clipped
);

    pcmvol_pkg::cmd_t    cmd;
    pcmvol_pkg::status_t status;

    pcmvol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcmvol_dp #(
        .VOLUME_FLOOR   (VOLUME_FLOOR),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
